### hdl/eil_pkg.sv
// ----------------------------------------------------------------------------
// eil_pkg: shared types and constants of the executable image loader
// Word packing, directory geometry, queue transaction and result codes.
// ----------------------------------------------------------------------------
package eil_pkg;

    // Directory geometry and address space
    localparam int DIR_ENTRIES    = 64;
    localparam int ADDR_BITS      = 18;
    localparam int IDX_W          = $clog2(DIR_ENTRIES);
    localparam int CNT_W          = $clog2(DIR_ENTRIES + 1);
    localparam int PAGE_SHIFT     = 9;
    localparam int CPAGE_W        = ADDR_BITS - PAGE_SHIFT;
    localparam int PAGE_WORDS     = 512;
    localparam int SKIP_WORDS     = 33;
    localparam int DIR_WORDS      = 128;
    localparam int WIP_W          = 10;
    localparam int PC_W           = 9;
    localparam int PAGES_W        = PC_W + 1;

    // Byte and word formats
    localparam int BYTE_W         = 8;
    localparam int BYTES_PER_WORD = 5;
    localparam int POS_W          = 3;
    localparam int BUF_W          = 32;
    localparam int WORD_W         = 36;
    localparam int HALF_W         = 18;
    localparam int OUT_ADDR_W     = 18;
    localparam int FILL_W         = 19;
    localparam logic [HALF_W-1:0] HDR_MAGIC = 18'o1776;
    localparam int HDR_MAX_COUNT  = 128;

    // Queue between front and back
    localparam int FIFO_DEPTH     = 4;
    localparam int FIFO_PTR_W     = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W     = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_WORD  = 2'd0,
        KIND_FILL  = 2'd1,
        KIND_DONE  = 2'd2,
        KIND_ERROR = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        Q_HDR_OK,
        Q_HDR_BAD,
        Q_DIR,
        Q_PAGE_END,
        Q_BODY
    } qcmd_t;

    typedef struct packed {
        qcmd_t              cmd;
        logic [WORD_W-1:0]  word;
        logic [IDX_W-1:0]   idx;
        logic               flag_half;  // first word of a directory pair
        logic [CNT_W-1:0]   count;      // entry count for Q_HDR_OK
    } qentry_t;

    typedef struct packed {
        logic valid;
        logic full;
    } fifo_status_t;

    typedef struct packed {
        logic               cpage_zero;
        logic [CPAGE_W-1:0] cpage_lo;
        logic [PC_W-1:0]    pagecount;
    } dir_rec_t;

    typedef enum logic [1:0] {
        FP_HEADER,
        FP_PAGE0,
        FP_BODY,
        FP_DEAD
    } front_phase_t;

    typedef enum logic [2:0] {
        ST_HEADER,
        ST_DIR,
        ST_FETCH,
        ST_EVAL,
        ST_SKIP,
        ST_LOAD,
        ST_FLUSH,
        ST_DONE
    } back_state_t;

endpackage

### hdl/eil_fifo.sv
// ----------------------------------------------------------------------------
// eil_fifo: short transaction queue between front and back
// Four slots, registered pointers and fill count.
// ----------------------------------------------------------------------------
module eil_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  eil_pkg::qentry_t     push_entry,
    input  logic                 pop,
    output eil_pkg::qentry_t     pop_entry,
    output eil_pkg::fifo_status_t status
);
    import eil_pkg::*;

    qentry_t               slots [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign pop_entry    = slots[rd_ptr_reg];
    assign status.valid = (count_reg != '0);
    assign status.full  = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));

endmodule

### hdl/eil_front.sv
// ----------------------------------------------------------------------------
// eil_front: byte packer and first-page classifier
// Packs five bytes per 36-bit word, checks the header, tags directory words.
// ----------------------------------------------------------------------------
module eil_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            file_byte,
    input  eil_pkg::fifo_status_t q_status,
    output logic                  q_push,
    output eil_pkg::qentry_t      q_entry
);
    import eil_pkg::*;

    front_phase_t       phase_reg, phase_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [BUF_W-1:0]   buf_reg, buf_next;
    logic [WIP_W-1:0]   wip_reg, wip_next;

    logic               accept;
    logic [WORD_W-1:0]  word;
    logic [HALF_W-1:0]  lh, rh;
    logic               hdr_bad;
    logic [7:0]         rh_m1;
    logic [6:0]         count_raw;
    logic [WIP_W-1:0]   wip_m1;
    logic [WIP_W-1:0]   idx_raw;
    logic               dir_word;

    assign in_stall = q_status.full;
    assign accept   = in_valid && !q_status.full;

    assign word    = {buf_reg, file_byte[3:0]};
    assign lh      = word[WORD_W-1:HALF_W];
    assign rh      = word[HALF_W-1:0];
    assign hdr_bad = (lh != HDR_MAGIC) || (rh > HALF_W'(HDR_MAX_COUNT));
    // rh is at most 128 here, so eight bits carry the count
    assign rh_m1     = rh[7:0] - 8'd1;
    assign count_raw = (rh == '0) ? 7'd0 : rh_m1[7:1];
    assign wip_m1    = wip_reg - 1'b1;
    assign idx_raw   = wip_m1 >> 1;
    assign dir_word  = (wip_reg <= WIP_W'(DIR_WORDS)) && (32'(idx_raw) < DIR_ENTRIES);

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        buf_next   = buf_reg;
        wip_next   = wip_reg;
        q_push     = 1'b0;

        q_entry.cmd       = Q_BODY;
        q_entry.word      = word;
        q_entry.idx       = IDX_W'(idx_raw);
        q_entry.flag_half = wip_reg[0];
        q_entry.count     = (32'(count_raw) > DIR_ENTRIES) ? CNT_W'(DIR_ENTRIES)
                                                           : CNT_W'(count_raw);

        if (accept && phase_reg != FP_DEAD)
        begin
            if (pos_reg != POS_W'(BYTES_PER_WORD - 1))
            begin
                buf_next = {buf_reg[BUF_W-BYTE_W-1:0], file_byte};
                pos_next = pos_reg + 1'b1;
            end
            else
            begin
                buf_next = '0;
                pos_next = '0;
                case (phase_reg)
                    FP_HEADER:
                    begin
                        q_push = 1'b1;
                        if (hdr_bad)
                        begin
                            q_entry.cmd = Q_HDR_BAD;
                            phase_next  = FP_DEAD;
                        end
                        else
                        begin
                            q_entry.cmd = Q_HDR_OK;
                            wip_next    = WIP_W'(1);
                            phase_next  = FP_PAGE0;
                        end
                    end
                    FP_PAGE0:
                    begin
                        if (dir_word)
                        begin
                            q_push      = 1'b1;
                            q_entry.cmd = Q_DIR;
                        end
                        if (wip_reg == WIP_W'(PAGE_WORDS - 1))
                        begin
                            q_push      = 1'b1;
                            q_entry.cmd = Q_PAGE_END;
                            wip_next    = '0;
                            phase_next  = FP_BODY;
                        end
                        else
                        begin
                            wip_next = wip_reg + 1'b1;
                        end
                    end
                    FP_BODY:
                    begin
                        q_push = 1'b1;
                    end
                    default:
                    begin
                        phase_next = FP_DEAD;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= FP_HEADER;
            pos_reg   <= '0;
            buf_reg   <= '0;
            wip_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            buf_reg   <= buf_next;
            wip_reg   <= wip_next;
        end
    end

endmodule

### hdl/eil_back.sv
// ----------------------------------------------------------------------------
// eil_back: directory store and load sequencer
// Walks directory entries, emits word writes, zero fills, done and error.
// ----------------------------------------------------------------------------
module eil_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  eil_pkg::fifo_status_t   q_status,
    input  eil_pkg::qentry_t        q_entry,
    output logic                    q_pop,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [1:0]              kind,
    output logic [17:0]             mem_address,
    output logic [35:0]             word_data,
    output logic [18:0]             fill_count,
    output logic                    last
);
    import eil_pkg::*;

    function automatic logic [ADDR_BITS-1:0] addr_add(input logic [ADDR_BITS-1:0] a,
                                                      input logic [FILL_W-1:0]    c);
        logic [ADDR_BITS+FILL_W-1:0] s;
        s = {{FILL_W{1'b0}}, a} + {{ADDR_BITS{1'b0}}, c};
        return s[ADDR_BITS-1:0];
    endfunction

    // Directory store: page fields and fpage flag written by separate words
    dir_rec_t           page_mem [DIR_ENTRIES];
    logic               flag_mem [DIR_ENTRIES];
    dir_rec_t           dir_rd_reg;
    logic               flag_rd_reg;
    logic               wr_page, wr_flag, rd_en;
    dir_rec_t           wr_rec;

    back_state_t            state_reg, state_next;
    logic [CNT_W-1:0]       entry_count_reg, entry_count_next;
    logic [CNT_W-1:0]       entry_index_reg, entry_index_next;
    logic [ADDR_BITS-1:0]   load_addr_reg, load_addr_next;
    logic [PAGES_W-1:0]     pages_reg, pages_next;
    logic [WIP_W-1:0]       wip_reg, wip_next;

    // Held result (last flag still open) and output register
    logic                   pend_valid_reg, pend_valid_next;
    kind_t                  pend_kind_reg, pend_kind_next;
    logic [OUT_ADDR_W-1:0]  pend_addr_reg, pend_addr_next;
    logic [WORD_W-1:0]      pend_data_reg, pend_data_next;
    logic [FILL_W-1:0]      pend_cnt_reg, pend_cnt_next;
    logic                   out_valid_reg, out_valid_next;
    kind_t                  out_kind_reg, out_kind_next;
    logic [OUT_ADDR_W-1:0]  out_addr_reg, out_addr_next;
    logic [WORD_W-1:0]      out_data_reg, out_data_next;
    logic [FILL_W-1:0]      out_cnt_reg, out_cnt_next;
    logic                   out_last_reg, out_last_next;

    logic                   out_free, can_move;
    logic                   do_push, do_flush, do_direct;
    kind_t                  r_kind;
    logic [OUT_ADDR_W-1:0]  r_addr;
    logic [WORD_W-1:0]      r_data;
    logic [FILL_W-1:0]      r_cnt;
    logic [ADDR_BITS-1:0]   base_addr, addr_inc;
    logic [PAGES_W-1:0]     eval_pages;
    logic [FILL_W-1:0]      eval_cnt, skip_cnt;

    assign out_free = !out_valid_reg || !out_stall;
    assign can_move = !pend_valid_reg || out_free;

    assign wr_rec.cpage_zero = (q_entry.word[HALF_W-1:0] == '0);
    assign wr_rec.cpage_lo   = q_entry.word[CPAGE_W-1:0];
    assign wr_rec.pagecount  = q_entry.word[WORD_W-1:WORD_W-PC_W];

    always_ff @(posedge clk)
    begin
        if (wr_page)
        begin
            page_mem[q_entry.idx] <= wr_rec;
        end
        if (wr_flag)
        begin
            flag_mem[q_entry.idx] <= (q_entry.word[HALF_W-1:0] != '0);
        end
        if (rd_en)
        begin
            dir_rd_reg  <= page_mem[entry_index_reg[IDX_W-1:0]];
            flag_rd_reg <= flag_mem[entry_index_reg[IDX_W-1:0]];
        end
    end

    assign base_addr  = {dir_rd_reg.cpage_lo, {PAGE_SHIFT{1'b0}}};
    assign eval_pages = {1'b0, dir_rd_reg.pagecount} + 1'b1;
    assign eval_cnt   = {eval_pages, {PAGE_SHIFT{1'b0}}};
    assign skip_cnt   = {pages_reg, {PAGE_SHIFT{1'b0}}} - FILL_W'(SKIP_WORDS);
    assign addr_inc   = load_addr_reg + 1'b1;

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        entry_count_next = entry_count_reg;
        entry_index_next = entry_index_reg;
        load_addr_next   = load_addr_reg;
        pages_next       = pages_reg;
        wip_next         = wip_reg;
        q_pop            = 1'b0;
        wr_page          = 1'b0;
        wr_flag          = 1'b0;
        rd_en            = 1'b0;
        do_push          = 1'b0;
        do_flush         = 1'b0;
        do_direct        = 1'b0;
        r_kind           = KIND_WORD;
        r_addr           = '0;
        r_data           = '0;
        r_cnt            = '0;

        case (state_reg)
            ST_HEADER:
            begin
                if (q_status.valid && out_free)
                begin
                    q_pop = 1'b1;
                    if (q_entry.cmd == Q_HDR_BAD)
                    begin
                        do_direct  = 1'b1;
                        r_kind     = KIND_ERROR;
                        state_next = ST_DONE;
                    end
                    else if (q_entry.cmd == Q_HDR_OK)
                    begin
                        entry_count_next = q_entry.count;
                        state_next       = ST_DIR;
                    end
                end
            end
            ST_DIR:
            begin
                if (q_status.valid)
                begin
                    q_pop = 1'b1;
                    if (q_entry.cmd == Q_DIR)
                    begin
                        wr_flag = q_entry.flag_half;
                        wr_page = !q_entry.flag_half;
                    end
                    else if (q_entry.cmd == Q_PAGE_END)
                    begin
                        entry_index_next = '0;
                        wip_next         = '0;
                        state_next       = ST_FETCH;
                    end
                end
            end
            ST_FETCH:
            begin
                if (entry_index_reg >= entry_count_reg)
                begin
                    if (can_move)
                    begin
                        do_push    = 1'b1;
                        r_kind     = KIND_DONE;
                        r_addr     = load_addr_reg[OUT_ADDR_W-1:0];
                        state_next = ST_FLUSH;
                    end
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (can_move)
                begin
                    load_addr_next = base_addr;
                    pages_next     = eval_pages;
                    wip_next       = '0;
                    if (dir_rd_reg.cpage_zero)
                    begin
                        do_flush   = 1'b1;
                        state_next = ST_SKIP;
                    end
                    else if (flag_rd_reg)
                    begin
                        do_flush   = 1'b1;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        do_push          = 1'b1;
                        r_kind           = KIND_FILL;
                        r_addr           = base_addr[OUT_ADDR_W-1:0];
                        r_cnt            = eval_cnt;
                        load_addr_next   = addr_add(base_addr, eval_cnt);
                        entry_index_next = entry_index_reg + 1'b1;
                        state_next       = ST_FETCH;
                    end
                end
            end
            ST_SKIP:
            begin
                if (q_status.valid && can_move)
                begin
                    q_pop          = 1'b1;
                    load_addr_next = addr_inc;
                    wip_next       = wip_reg + 1'b1;
                    if (wip_reg == WIP_W'(SKIP_WORDS - 1))
                    begin
                        if (flag_rd_reg)
                        begin
                            state_next = ST_LOAD;
                        end
                        else
                        begin
                            do_push          = 1'b1;
                            r_kind           = KIND_FILL;
                            r_addr           = addr_inc[OUT_ADDR_W-1:0];
                            r_cnt            = skip_cnt;
                            load_addr_next   = addr_add(addr_inc, skip_cnt);
                            entry_index_next = entry_index_reg + 1'b1;
                            state_next       = ST_FETCH;
                        end
                    end
                end
            end
            ST_LOAD:
            begin
                if (q_status.valid && out_free)
                begin
                    q_pop          = 1'b1;
                    r_kind         = KIND_WORD;
                    r_addr         = load_addr_reg[OUT_ADDR_W-1:0];
                    r_data         = q_entry.word;
                    load_addr_next = addr_inc;
                    if (wip_reg == WIP_W'(PAGE_WORDS - 1))
                    begin
                        wip_next   = '0;
                        pages_next = pages_reg - 1'b1;
                        if (pages_reg == PAGES_W'(1))
                        begin
                            // entry finished: more results may follow
                            do_push          = 1'b1;
                            entry_index_next = entry_index_reg + 1'b1;
                            state_next       = ST_FETCH;
                        end
                        else
                        begin
                            do_direct = 1'b1;
                        end
                    end
                    else
                    begin
                        wip_next  = wip_reg + 1'b1;
                        do_direct = 1'b1;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (can_move)
                begin
                    do_flush   = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                q_pop = q_status.valid;
            end
            default:
            begin
                state_next = ST_HEADER;
            end
        endcase
    end

    // Result path: held result -> output register; direct results bypass the hold
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_kind_next  = pend_kind_reg;
        pend_addr_next  = pend_addr_reg;
        pend_data_next  = pend_data_reg;
        pend_cnt_next   = pend_cnt_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_kind_next   = out_kind_reg;
        out_addr_next   = out_addr_reg;
        out_data_next   = out_data_reg;
        out_cnt_next    = out_cnt_reg;
        out_last_next   = out_last_reg;

        if ((do_push || do_flush) && pend_valid_reg)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = pend_kind_reg;
            out_addr_next  = pend_addr_reg;
            out_data_next  = pend_data_reg;
            out_cnt_next   = pend_cnt_reg;
            out_last_next  = do_flush;
        end
        if (do_flush)
        begin
            pend_valid_next = 1'b0;
        end
        if (do_push)
        begin
            pend_valid_next = 1'b1;
            pend_kind_next  = r_kind;
            pend_addr_next  = r_addr;
            pend_data_next  = r_data;
            pend_cnt_next   = r_cnt;
        end
        if (do_direct)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = r_kind;
            out_addr_next  = r_addr;
            out_data_next  = r_data;
            out_cnt_next   = r_cnt;
            out_last_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_HEADER;
            entry_count_reg <= '0;
            entry_index_reg <= '0;
            load_addr_reg   <= '0;
            pages_reg       <= '0;
            wip_reg         <= '0;
            pend_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            entry_count_reg <= entry_count_next;
            entry_index_reg <= entry_index_next;
            load_addr_reg   <= load_addr_next;
            pages_reg       <= pages_next;
            wip_reg         <= wip_next;
            pend_valid_reg  <= pend_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_kind_reg <= pend_kind_next;
        pend_addr_reg <= pend_addr_next;
        pend_data_reg <= pend_data_next;
        pend_cnt_reg  <= pend_cnt_next;
        out_kind_reg  <= out_kind_next;
        out_addr_reg  <= out_addr_next;
        out_data_reg  <= out_data_next;
        out_cnt_reg   <= out_cnt_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid   = out_valid_reg;
    assign kind        = out_kind_reg;
    assign mem_address = out_addr_reg;
    assign word_data   = out_data_reg;
    assign fill_count  = out_cnt_reg;
    assign last        = out_last_reg;

endmodule

### hdl/exe_image_loader.sv
// ----------------------------------------------------------------------------
// exe_image_loader: streaming loader for 36-bit executable images
// Packs file bytes into words, parses the directory page and turns each
// directory entry into memory word writes or a zero-fill request.
// ----------------------------------------------------------------------------
//
//  channel | signals                                         | role
//  --------+-------------------------------------------------+----------------
//  in      | in_valid, in_stall, file_byte                   | image bytes
//  out     | out_valid, out_stall, kind, mem_address,        | results, last
//          | word_data, fill_count, last                     | flag
//
//  One byte is taken per cycle while the front/back queue has room; every
//  fifth byte completes a word; header, directory, page-end and body words
//  each become one queue transaction. The back retires one queued word per
//  cycle unless out_stall holds it; a zero-fill entry needs a directory read
//  and an evaluate step; long fill chains fill the queue and raise in_stall.
//  Reset (rst_n, async, active low) returns both halves to header parsing;
//  the directory store is not cleared and needs no clearing pass.
//  out_stall holds the output register and stops the back; the four-slot
//  queue absorbs up to four words before in_stall rises.
//
module exe_image_loader (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  file_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [17:0] mem_address,
    output logic [35:0] word_data,
    output logic [18:0] fill_count,
    output logic        last
);
    import eil_pkg::*;

    // Front to queue
    logic         push;
    qentry_t      push_entry;
    // Queue to back
    logic         pop;
    qentry_t      pop_entry;
    fifo_status_t q_status;

    // Front: packs bytes, checks the header, tags directory and body words
    eil_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .file_byte (file_byte),
        .q_status  (q_status),
        .q_push    (push),
        .q_entry   (push_entry)
    );

    // Decoupling queue: lets the front keep taking bytes during fill chains
    eil_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .status     (q_status)
    );

    // Back: directory store, entry sequencer and result registers
    eil_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_status    (q_status),
        .q_entry     (pop_entry),
        .q_pop       (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .mem_address (mem_address),
        .word_data   (word_data),
        .fill_count  (fill_count),
        .last        (last)
    );

endmodule
